@@ rtl/core/bdd_pkg.sv @@
package bdd_pkg;

  // Input word layout (tdata, lowest bit first)
  localparam int CTRL_W     = 8;
  localparam int GROUP_W    = 32;
  localparam int N_GROUPS   = 4;
  localparam int SAMPLE_W   = 32;
  localparam int GROUP_LSB  = CTRL_W;
  localparam int SEED_LSB   = GROUP_LSB + N_GROUPS * GROUP_W;
  localparam int IN_DATA_W  = SEED_LSB + SAMPLE_W;
  localparam int OUT_USER_W = 2;

  localparam logic [CTRL_W-1:0] BAD_CODE = 8'd9;

  // Group codes from the control byte
  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [1:0] CODE_BYTE = 2'd1;
  localparam logic [1:0] CODE_HALF = 2'd2;
  localparam logic [1:0] CODE_WORD = 2'd3;

  // out_tuser bit positions
  localparam int USER_VALID_BIT = 0;
  localparam int USER_BAD_BIT   = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLAG
  } bdd_state_t;

  typedef struct packed {
    logic load;   // capture the bundle, apply the seed
    logic step;   // emit one decoded sample
    logic flag;   // emit the single bad/empty word
  } bdd_cmd_t;

  typedef struct packed {
    logic in_bad;     // incoming control byte marks a bad bundle
    logic in_empty;   // incoming bundle holds no differences
    logic diff_last;  // current difference is the bundle's last
    logic slot_free;  // output register can take a word this cycle
  } bdd_stat_t;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } bdd_find_t;

endpackage

@@ rtl/core/bundle_difference_decoder_unit.sv @@
// Channel  | Dir | Word contents
// ---------+-----+-------------------------------------------------------------
// in_      | in  | one compressed bundle: control byte, four data groups, seed
// out_     | out | one reconstructed sample, or one bad/empty marker word
//
// Flow: a bundle is taken in while the controller is idle, then its decoded
// samples (1 to 16) follow one by one; a bad or empty bundle gives one marker.
// The rate is set by the single adder on the running sample and the one output
// register, which take one difference per cycle while out_tready does not stall.
// Reset: rst_n low clears the controller, the output valid flag and the running
// sample (to zero).
// Stalls: out_tready low holds the output word and pauses the walk; a new
// bundle is taken while the bundle's last word still waits in the output.
module bundle_difference_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // control_byte[7:0], group_zero[39:8], group_one[71:40],
  // group_two[103:72], group_three[135:104], seed_value[167:136]
  input  logic [bdd_pkg::IN_DATA_W-1:0]        in_tdata,
  // seed_enable
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // sample[31:0]
  output logic [bdd_pkg::SAMPLE_W-1:0]         out_tdata,
  // sample_valid[0], bad_bundle[1]
  output logic [bdd_pkg::OUT_USER_W-1:0]       out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);
  import bdd_pkg::*;

  bdd_cmd_t  cmd;
  bdd_stat_t stat;

  // Sequence load, per-sample steps and the marker word
  bdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the bundle, pick differences, accumulate and drive the output word
  bdd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A taken bundle blocks the input until its words are issued
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a bundle was taken");

  // A bad-bundle marker carries no sample and closes the bundle
  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[USER_BAD_BIT]) |->
      (!out_tuser[USER_VALID_BIT] && out_tlast && (out_tdata == '0)))
    else $error("malformed bad-bundle word");

  // Any word without a sample is the bundle's only and final word
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[USER_VALID_BIT]) |-> (out_tlast && (out_tdata == '0)))
    else $error("marker word not last or carries data");

endmodule

@@ rtl/core/bdd_ctrl.sv @@
module bdd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bdd_pkg::bdd_stat_t  stat,
  output bdd_pkg::bdd_cmd_t   cmd
);
  import bdd_pkg::*;

  bdd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (stat.in_bad || stat.in_empty) ? ST_FLAG : ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.slot_free && stat.diff_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLAG: begin
        if (stat.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_RUN:  cmd.step = stat.slot_free;
      ST_FLAG: cmd.flag = stat.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/bdd_datapath.sv @@
module bdd_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [bdd_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic                                 in_tuser,
  input  bdd_pkg::bdd_cmd_t                    cmd,
  output bdd_pkg::bdd_stat_t                   stat,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [bdd_pkg::SAMPLE_W-1:0]         out_tdata,
  output logic [bdd_pkg::OUT_USER_W-1:0]       out_tuser,
  output logic                                 out_tlast
);
  import bdd_pkg::*;

  // Lowest group at or above start whose code is not CODE_NONE
  function automatic bdd_find_t find_group(input logic [N_GROUPS-1:0][1:0] codes,
                                           input logic [2:0] start);
    bdd_find_t res;
    res = '0;
    for (int i = N_GROUPS - 1; i >= 0; i--) begin
      if ((3'(i) >= start) && (codes[i] != CODE_NONE)) begin
        res.found = 1'b1;
        res.idx   = 2'(i);
      end
    end
    return res;
  endfunction

  logic [N_GROUPS-1:0][GROUP_W-1:0] grp_r;
  logic [N_GROUPS-1:0][1:0]         codes_r;
  logic [1:0]                       g_r, s_r;
  logic                             bad_r;
  logic [SAMPLE_W-1:0]              prev_r;
  logic                             out_valid_r;
  logic [SAMPLE_W-1:0]              out_data_r;
  logic [OUT_USER_W-1:0]            out_user_r;
  logic [OUT_USER_W-1:0]            out_user_nxt;
  logic                             out_last_r;

  logic [CTRL_W-1:0]                in_ctrl;
  logic [N_GROUPS-1:0][1:0]         in_codes;
  bdd_find_t                        first_grp, next_grp;
  logic [GROUP_W-1:0]               cur_word;
  logic [1:0]                       cur_code;
  logic [1:0]                       last_sub;
  logic                             sub_end;
  logic [SAMPLE_W-1:0]              diff;
  logic [SAMPLE_W-1:0]              sum;

  assign in_ctrl = in_tdata[CTRL_W-1:0];

  // First group sits in the top bits of the control byte
  always_comb begin
    for (int g = 0; g < N_GROUPS; g++) begin
      in_codes[g] = in_ctrl[CTRL_W-1-2*g -: 2];
    end
  end

  assign first_grp = find_group(in_codes, 3'd0);
  assign next_grp  = find_group(codes_r, {1'b0, g_r} + 3'd1);

  assign cur_word = grp_r[g_r];
  assign cur_code = codes_r[g_r];

  always_comb begin
    case (cur_code)
      CODE_BYTE: begin
        last_sub = 2'd3;
        diff     = {{24{cur_word[8*s_r+7]}}, cur_word[8*s_r +: 8]};
      end
      CODE_HALF: begin
        last_sub = 2'd1;
        diff     = {{16{cur_word[16*s_r[0]+15]}}, cur_word[16*s_r[0] +: 16]};
      end
      default: begin
        last_sub = 2'd0;
        diff     = cur_word;
      end
    endcase
  end

  assign sub_end = (s_r == last_sub);
  assign sum     = prev_r + diff;

  assign stat.in_bad    = (in_ctrl == BAD_CODE);
  assign stat.in_empty  = !first_grp.found;
  assign stat.diff_last = sub_end && !next_grp.found;
  assign stat.slot_free = !out_valid_r || out_tready;

  // Bundle capture and walk over the differences
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grp_r   <= in_tdata[GROUP_LSB +: N_GROUPS * GROUP_W];
      codes_r <= in_codes;
      g_r     <= first_grp.idx;
      s_r     <= 2'd0;
      bad_r   <= stat.in_bad;
    end else if (cmd.step) begin
      if (sub_end) begin
        g_r <= next_grp.idx;
        s_r <= 2'd0;
      end else begin
        s_r <= s_r + 2'd1;
      end
    end
  end

  // Running sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.load && in_tuser) begin
      prev_r <= in_tdata[SEED_LSB +: SAMPLE_W];
    end else if (cmd.step) begin
      prev_r <= sum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step || cmd.flag) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sample words flag valid; marker words flag bad only for a bad bundle
  always_comb begin
    out_user_nxt                 = '0;
    out_user_nxt[USER_VALID_BIT] = cmd.step;
    out_user_nxt[USER_BAD_BIT]   = cmd.flag && bad_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data_r <= sum;
      out_user_r <= out_user_nxt;
      out_last_r <= stat.diff_last;
    end else if (cmd.flag) begin
      out_data_r <= '0;
      out_user_r <= out_user_nxt;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

// Bench for the bundle difference decoder. Each input word is one compressed
// bundle; every accepted word is run through a local model of the decoder. That
// model queues the samples that the bundle must produce. A monitor pops one
// sample per output handshake and compares it field by field.
module tb;
  import bdd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int GAP_MAX     = 12;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_LONG   = 600;
  localparam int RANDOM_ITEMS = 400;
  localparam int MAX_DIFFS   = 16;

  // Bundle as it travels on in_tdata: the last member sits in the lowest bits.
  typedef struct packed {
    logic [SAMPLE_W-1:0] seed_value;
    logic [GROUP_W-1:0]  group_three;
    logic [GROUP_W-1:0]  group_two;
    logic [GROUP_W-1:0]  group_one;
    logic [GROUP_W-1:0]  group_zero;
    logic [CTRL_W-1:0]   control_byte;
  } bundle_t;

  // One expected output word.
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                valid;
    logic                bad;
    logic                last;
  } sample_word_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  // control_byte, group_zero .. group_three, seed_value
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // seed_enable
  logic                  in_tuser   = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // sample
  logic [SAMPLE_W-1:0]   out_tdata;
  // sample_valid, bad_bundle
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // Idle limits for both sides. The receiver takes a long hold-off on request.
  int src_max     = GAP_MAX;
  int sink_max    = GAP_MAX;
  int hold_cycles = 0;
  int fail_count  = 0;
  int cycle_count = 0;

  // Model state: the running sample and the samples not yet seen on the output.
  logic [SAMPLE_W-1:0] running_sample = '0;
  sample_word_t        pending_words[$];

  bundle_difference_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop the run on a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Decode one accepted bundle and queue the samples that it yields.
  // The seed load comes first, so a bad bundle still takes its seed.
  task automatic reconstruct_samples(input bundle_t b, input logic seed_en);
    logic [GROUP_W-1:0]  grp [N_GROUPS];
    logic [SAMPLE_W-1:0] diffs [MAX_DIFFS];
    logic [1:0]          code;
    int                  n;
    int                  g;
    int                  k;
    grp[0] = b.group_zero;
    grp[1] = b.group_one;
    grp[2] = b.group_two;
    grp[3] = b.group_three;
    n = 0;
    if (seed_en) running_sample = b.seed_value;
    if (b.control_byte == BAD_CODE) begin
      pending_words.push_back('{sample: '0, valid: 1'b0, bad: 1'b1, last: 1'b1});
      return;
    end
    // Walk the group codes from the top bits of the control byte down.
    for (g = 0; g < N_GROUPS; g++) begin
      code = b.control_byte[CTRL_W-1-2*g -: 2];
      case (code)
        CODE_BYTE: begin
          for (k = 0; k < 4; k++) begin
            diffs[n] = {{24{grp[g][8*k+7]}}, grp[g][8*k +: 8]};
            n++;
          end
        end
        CODE_HALF: begin
          for (k = 0; k < 2; k++) begin
            diffs[n] = {{16{grp[g][16*k+15]}}, grp[g][16*k +: 16]};
            n++;
          end
        end
        CODE_WORD: begin
          diffs[n] = grp[g];
          n++;
        end
        default: ;
      endcase
    end
    // A bundle with every group unused yields one empty marker word.
    if (n == 0) begin
      pending_words.push_back('{sample: '0, valid: 1'b0, bad: 1'b0, last: 1'b1});
      return;
    end
    for (k = 0; k < n; k++) begin
      running_sample = running_sample + diffs[k];
      pending_words.push_back('{sample: running_sample, valid: 1'b1, bad: 1'b0,
                                last: (k == n - 1)});
    end
  endtask

  // Offer one bundle after a random gap; hold it until the block takes it.
  // Leave valid high afterwards so that a gapless next word follows directly.
  task automatic send_bundle(input bundle_t b, input logic seed_en);
    int gap;
    gap = $urandom_range(0, src_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= b;
    in_tuser  <= seed_en;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    reconstruct_samples(b, seed_en);
  endtask

  // Drop valid and hold until every queued sample has come out.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic bundle_t make_bundle(input logic [CTRL_W-1:0] ctrl,
                                          input logic [GROUP_W-1:0] g0,
                                          input logic [GROUP_W-1:0] g1,
                                          input logic [GROUP_W-1:0] g2,
                                          input logic [GROUP_W-1:0] g3,
                                          input logic [SAMPLE_W-1:0] seed);
    bundle_t b;
    b.control_byte = ctrl;
    b.group_zero   = g0;
    b.group_one    = g1;
    b.group_two    = g2;
    b.group_three  = g3;
    b.seed_value   = seed;
    return b;
  endfunction

  // Favor bad, empty and full bundles a little over plain random codes.
  function automatic logic [CTRL_W-1:0] pick_control();
    case ($urandom_range(0, 19))
      0:       return BAD_CODE;
      1:       return '0;
      2:       return {4{CODE_BYTE}};
      3:       return {4{CODE_WORD}};
      4:       return {4{CODE_HALF}};
      default: return CTRL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [GROUP_W-1:0] pick_group();
    case ($urandom_range(0, 9))
      0:       return 32'h8080_8080;
      1:       return 32'h7F7F_7F7F;
      2:       return 32'h7FFF_8000;
      3:       return 32'h8000_0000;
      4:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_bundle();
    bundle_t b;
    b = make_bundle(pick_control(), pick_group(), pick_group(), pick_group(),
                    pick_group(), $urandom());
    send_bundle(b, ($urandom_range(0, 7) == 0));
  endtask

  // Directed words: extremes of each group code, bad and empty bundles,
  // seeding, and the wrap of the running sample.
  task automatic test_directed_cases();
    // Empty bundle straight after reset, then one with data in unused groups.
    send_bundle(make_bundle(8'h00, '0, '0, '0, '0, '0), 1'b0);
    send_bundle(make_bundle(8'h00, '1, '1, '1, '1, '1), 1'b0);
    // Bad bundle alone, then with a seed that must still be loaded.
    send_bundle(make_bundle(BAD_CODE, '1, '1, '1, '1, 32'h1234_5678), 1'b0);
    send_bundle(make_bundle(BAD_CODE, '1, '1, '1, '1, 32'h1234_5678), 1'b1);
    send_bundle(make_bundle(8'hC0, '0, '1, '1, '1, '0), 1'b0);
    // Wrap through the top and the bottom of the signed range.
    send_bundle(make_bundle(8'hC0, 32'h0000_0001, '0, '0, '0, 32'h7FFF_FFFF), 1'b1);
    send_bundle(make_bundle(8'hC0, 32'hFFFF_FFFF, '0, '0, '0, 32'h8000_0000), 1'b1);
    // Every group of one code, at its extremes.
    send_bundle(make_bundle({4{CODE_BYTE}}, 32'h8080_8080, 32'h7F7F_7F7F,
                            32'h0000_0000, 32'hFFFF_FFFF, '0), 1'b0);
    send_bundle(make_bundle({4{CODE_HALF}}, 32'h7FFF_8000, 32'h8000_7FFF,
                            32'hFFFF_0001, 32'h0000_FFFF, '0), 1'b0);
    send_bundle(make_bundle({4{CODE_WORD}}, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'h0000_0001, '0), 1'b0);
    // Mixed codes in both orders, and a single group in the last slot.
    send_bundle(make_bundle({CODE_NONE, CODE_BYTE, CODE_HALF, CODE_WORD},
                            '1, 32'h01FF_7F80, 32'h8001_7FFE, 32'hA5A5_5A5A, '0), 1'b0);
    send_bundle(make_bundle({CODE_WORD, CODE_HALF, CODE_BYTE, CODE_NONE},
                            32'h0BAD_F00D, 32'hFFFE_0002, 32'h8001_FF7F, '1, '0), 1'b0);
    send_bundle(make_bundle({CODE_NONE, CODE_NONE, CODE_NONE, CODE_WORD},
                            '1, '1, '1, 32'h0000_0010, '0), 1'b0);
    // Codes just beside the bad value.
    send_bundle(make_bundle(8'h08, '1, '1, 32'h8000_0001, '1, '0), 1'b0);
    send_bundle(make_bundle(8'h0A, '1, '1, 32'h7FFF_7FFF, 32'h8000_8000, '0), 1'b0);
    send_bundle(make_bundle({CODE_BYTE, CODE_NONE, CODE_NONE, CODE_NONE},
                            32'h80FF_017F, '1, '1, '1, 32'hFFFF_FFFF), 1'b1);
    // Seed on an empty bundle, then read it back with a zero difference.
    send_bundle(make_bundle(8'h00, '1, '1, '1, '1, 32'hDEAD_BEEF), 1'b1);
    send_bundle(make_bundle(8'hC0, '0, '0, '0, '0, '0), 1'b0);
  endtask

  // Random bundles; one stretch runs with no idling on either side.
  task automatic test_random_stream();
    int i;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        src_max  = 0;
        sink_max = 0;
      end else if (i == RANDOM_ITEMS / 2) begin
        src_max  = GAP_MAX;
        sink_max = GAP_MAX;
      end
      send_random_bundle();
    end
  endtask

  // Stall the output for a long stretch while the input keeps offering
  // full bundles, so the block fills and holds off its input.
  task automatic test_output_backpressure();
    int i;
    src_max     = 0;
    hold_cycles = HOLD_LONG;
    for (i = 0; i < 20; i++) begin
      send_bundle(make_bundle({4{CODE_BYTE}}, pick_group(), pick_group(),
                              pick_group(), pick_group(), $urandom()), (i == 0));
    end
    src_max = GAP_MAX;
    wait_until_drained();
  endtask

  // Pause the input until the output has caught up, then resume.
  task automatic test_sender_pause();
    int i;
    for (i = 0; i < 6; i++) send_random_bundle();
    wait_until_drained();
    for (i = 0; i < 6; i++) send_random_bundle();
    wait_until_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_stream();
    test_output_backpressure();
    test_sender_pause();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Drive out_tready: a random stall before each word, and a long hold-off on
  // request, counted here.
  initial begin : drive_ready
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = $urandom_range(0, sink_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Compare each output word with the oldest queued sample.
  always @(posedge clk) begin : check_words
    sample_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("output word %h with no sample pending", out_tdata);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_tdata !== want.sample) begin
          $error("sample: expected %h, got %h", want.sample, out_tdata);
          fail_count++;
        end
        if (out_tuser[USER_VALID_BIT] !== want.valid) begin
          $error("sample_valid: expected %b, got %b", want.valid,
                 out_tuser[USER_VALID_BIT]);
          fail_count++;
        end
        if (out_tuser[USER_BAD_BIT] !== want.bad) begin
          $error("bad_bundle: expected %b, got %b", want.bad, out_tuser[USER_BAD_BIT]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

endmodule

@@ bundle_difference_decoder_unit.f @@
rtl/core/bdd_pkg.sv
rtl/core/bdd_ctrl.sv
rtl/core/bdd_datapath.sv
rtl/core/bundle_difference_decoder_unit.sv
bench/tb.sv
